@@ src/input_event_to_hid_report_assert.svh @@
// Assertion macros for the keyboard and mouse HID report converter
`ifndef INPUT_EVENT_TO_HID_REPORT_ASSERT_SVH
`define INPUT_EVENT_TO_HID_REPORT_ASSERT_SVH
`ifndef SYNTH
`define IETH_ASSERT_IMP(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("ieth: implication check failed");
`define IETH_ASSERT_NXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("ieth: next-cycle check failed");
`else
`define IETH_ASSERT_IMP(label, pre, post)
`define IETH_ASSERT_NXT(label, pre, post)
`endif
`endif

@@ src/ieth_pkg.sv @@
// Shared types, constants and the key code table of the HID report converter
package ieth_pkg;

   localparam int KEY_SLOTS_DEFAULT = 6;
   localparam int MAX_SLOTS         = 6;
   localparam int SLOT_IDX_W        = 3;
   localparam int MAP_ROWS          = 4;
   localparam int MAP_ROW_W         = 64;
   localparam int ROW_IDX_W         = 2;
   localparam int BIT_IDX_W         = 6;
   localparam int KEY_CODE_W        = 8;

   typedef logic [SLOT_IDX_W-1:0] slot_idx_type;

   localparam logic [1:0] MODE_KEY    = 2'd0;
   localparam logic [1:0] MODE_MOVE   = 2'd1;
   localparam logic [1:0] MODE_BUTTON = 2'd2;
   localparam logic [1:0] MODE_WHEEL  = 2'd3;

   localparam logic [9:0] BUTTON_CODE_LEFT   = 10'h110;
   localparam logic [9:0] BUTTON_CODE_RIGHT  = 10'h111;
   localparam logic [9:0] BUTTON_CODE_MIDDLE = 10'h112;

   localparam logic [1:0] REPORT_ID_KBD   = 2'd1;
   localparam logic [1:0] REPORT_ID_MOUSE = 2'd2;
   localparam logic [3:0] LEN_KBD         = 4'd8;
   localparam logic [3:0] LEN_MOUSE       = 4'd7;

   localparam logic [7:0] MOD_BASE = 8'he0;

   typedef struct packed {
      logic                  start;
      logic                  step;
      logic                  held;
      logic [KEY_CODE_W-1:0] code;
   } scan_ctl_type;

   function automatic logic [7:0] code_lookup(input logic [KEY_CODE_W-1:0] code);
      logic [7:0] hid;
      hid = 8'h00;
      unique case (code)
         8'd1:   hid = 8'h29;  8'd2:   hid = 8'h1e;  8'd3:   hid = 8'h1f;  8'd4:   hid = 8'h20;
         8'd5:   hid = 8'h21;  8'd6:   hid = 8'h22;  8'd7:   hid = 8'h23;  8'd8:   hid = 8'h24;
         8'd9:   hid = 8'h25;  8'd10:  hid = 8'h26;  8'd11:  hid = 8'h27;  8'd12:  hid = 8'h2d;
         8'd13:  hid = 8'h2e;  8'd14:  hid = 8'h2a;  8'd15:  hid = 8'h2b;  8'd16:  hid = 8'h14;
         8'd17:  hid = 8'h1a;  8'd18:  hid = 8'h08;  8'd19:  hid = 8'h15;  8'd20:  hid = 8'h17;
         8'd21:  hid = 8'h1c;  8'd22:  hid = 8'h18;  8'd23:  hid = 8'h0c;  8'd24:  hid = 8'h12;
         8'd25:  hid = 8'h13;  8'd26:  hid = 8'h2f;  8'd27:  hid = 8'h30;  8'd28:  hid = 8'h28;
         8'd29:  hid = 8'he0;  8'd30:  hid = 8'h04;  8'd31:  hid = 8'h16;  8'd32:  hid = 8'h07;
         8'd33:  hid = 8'h09;  8'd34:  hid = 8'h0a;  8'd35:  hid = 8'h0b;  8'd36:  hid = 8'h0d;
         8'd37:  hid = 8'h0e;  8'd38:  hid = 8'h0f;  8'd39:  hid = 8'h33;  8'd40:  hid = 8'h34;
         8'd41:  hid = 8'h35;  8'd42:  hid = 8'he1;  8'd43:  hid = 8'h31;  8'd44:  hid = 8'h1d;
         8'd45:  hid = 8'h1b;  8'd46:  hid = 8'h06;  8'd47:  hid = 8'h19;  8'd48:  hid = 8'h05;
         8'd49:  hid = 8'h11;  8'd50:  hid = 8'h10;  8'd51:  hid = 8'h36;  8'd52:  hid = 8'h37;
         8'd53:  hid = 8'h38;  8'd54:  hid = 8'he5;  8'd55:  hid = 8'h55;  8'd56:  hid = 8'he2;
         8'd57:  hid = 8'h2c;  8'd58:  hid = 8'h39;  8'd59:  hid = 8'h3a;  8'd60:  hid = 8'h3b;
         8'd61:  hid = 8'h3c;  8'd62:  hid = 8'h3d;  8'd63:  hid = 8'h3e;  8'd64:  hid = 8'h3f;
         8'd65:  hid = 8'h40;  8'd66:  hid = 8'h41;  8'd67:  hid = 8'h42;  8'd68:  hid = 8'h43;
         8'd69:  hid = 8'h53;  8'd70:  hid = 8'h47;  8'd71:  hid = 8'h5f;  8'd72:  hid = 8'h60;
         8'd73:  hid = 8'h61;  8'd74:  hid = 8'h56;  8'd75:  hid = 8'h5c;  8'd76:  hid = 8'h5d;
         8'd77:  hid = 8'h5e;  8'd78:  hid = 8'h57;  8'd79:  hid = 8'h59;  8'd80:  hid = 8'h5a;
         8'd81:  hid = 8'h5b;  8'd82:  hid = 8'h62;  8'd83:  hid = 8'h63;  8'd85:  hid = 8'h94;
         8'd86:  hid = 8'h64;  8'd87:  hid = 8'h44;  8'd88:  hid = 8'h45;  8'd89:  hid = 8'h87;
         8'd90:  hid = 8'h92;  8'd91:  hid = 8'h93;  8'd92:  hid = 8'h8a;  8'd93:  hid = 8'h88;
         8'd94:  hid = 8'h8b;  8'd96:  hid = 8'h58;  8'd97:  hid = 8'he4;  8'd98:  hid = 8'h54;
         8'd99:  hid = 8'h46;  8'd100: hid = 8'he6;  8'd102: hid = 8'h4a;  8'd103: hid = 8'h52;
         8'd104: hid = 8'h4b;  8'd105: hid = 8'h50;  8'd106: hid = 8'h4f;  8'd107: hid = 8'h4d;
         8'd108: hid = 8'h51;  8'd109: hid = 8'h4e;  8'd110: hid = 8'h49;  8'd111: hid = 8'h4c;
         8'd113: hid = 8'h7f;  8'd114: hid = 8'h81;  8'd115: hid = 8'h80;  8'd116: hid = 8'h66;
         8'd117: hid = 8'h67;  8'd118: hid = 8'hd7;  8'd119: hid = 8'h48;  8'd121: hid = 8'h85;
         8'd122: hid = 8'h90;  8'd123: hid = 8'h91;  8'd124: hid = 8'h89;  8'd125: hid = 8'he3;
         8'd126: hid = 8'he7;  8'd127: hid = 8'h65;  8'd129: hid = 8'h79;  8'd131: hid = 8'h7a;
         8'd132: hid = 8'h77;  8'd133: hid = 8'h7c;  8'd134: hid = 8'h74;  8'd135: hid = 8'h7d;
         8'd136: hid = 8'h7e;  8'd137: hid = 8'h7b;  8'd138: hid = 8'h75;  8'd179: hid = 8'hb6;
         8'd180: hid = 8'hb7;  8'd183: hid = 8'h68;  8'd184: hid = 8'h69;  8'd185: hid = 8'h6a;
         8'd186: hid = 8'h6b;  8'd187: hid = 8'h6c;  8'd188: hid = 8'h6d;  8'd189: hid = 8'h6e;
         8'd190: hid = 8'h6f;  8'd191: hid = 8'h70;  8'd192: hid = 8'h71;  8'd193: hid = 8'h72;
         8'd194: hid = 8'h73;
         default: hid = 8'h00;
      endcase
      return hid;
   endfunction

endpackage

@@ src/ieth_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module ieth_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/ieth_scan.sv @@
// Key scan unit: table lookup, modifier collection and key slot filling
module ieth_scan #(
   parameter int KEY_SLOTS = ieth_pkg::KEY_SLOTS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ieth_pkg::scan_ctl_type               ctl,
   output logic [7:0]                           mods,
   output logic [ieth_pkg::MAX_SLOTS-1:0][7:0]  slots
);

   localparam ieth_pkg::slot_idx_type SLOT_LIMIT = ieth_pkg::slot_idx_type'(KEY_SLOTS);

   logic [7:0]                          hid;
   logic [7:0]                          mods_ff, mods_in;
   logic [ieth_pkg::MAX_SLOTS-1:0][7:0] slots_ff, slots_in;
   ieth_pkg::slot_idx_type              used_ff, used_in;

   always_comb begin
      hid      = ieth_pkg::code_lookup(ctl.code);
      mods_in  = mods_ff;
      slots_in = slots_ff;
      used_in  = used_ff;
      if (ctl.start) begin
         mods_in  = '0;
         slots_in = '0;
         used_in  = '0;
      end else if (ctl.step && ctl.held && (hid != 8'h00)) begin
         if (hid >= ieth_pkg::MOD_BASE) begin
            mods_in = mods_ff | (8'h01 << hid[2:0]);
         end else if (used_ff < SLOT_LIMIT) begin
            slots_in[used_ff] = hid;
            used_in           = used_ff + ieth_pkg::slot_idx_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
      mods_ff  <= mods_in;
      slots_ff <= slots_in;
   end

   assign mods  = mods_ff;
   assign slots = slots_ff;

endmodule

@@ src/input_event_to_hid_report.sv @@
// Keyboard and mouse event to HID report converter, top level.
// Mouse events: report, if any, offered the cycle after the transfer; one transfer a cycle at best.
// A key that changes the map blocks the input until its report is loaded. In order: the check;
// per 64-bit row of the map RAM, a read (load and latch) and one scan unit step per bit; the
// report load into the output register. A key that leaves the map unchanged gives no report.
// Synchronous reset clears the row valid bits, buttons and sequencer at once; no clearing pass.
`include "input_event_to_hid_report_assert.svh"
module input_event_to_hid_report #(
   parameter int KEY_SLOTS = ieth_pkg::KEY_SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [9:0]         req_event_code,
   input  logic               req_pressed,
   input  logic signed [15:0] req_delta_x,
   input  logic signed [15:0] req_delta_y,
   input  logic signed [7:0]  req_wheel_delta,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_report_id,
   output logic [7:0]         rsp_byte1,
   output logic [7:0]         rsp_byte2,
   output logic [7:0]         rsp_byte3,
   output logic [7:0]         rsp_byte4,
   output logic [7:0]         rsp_byte5,
   output logic [7:0]         rsp_byte6,
   output logic [7:0]         rsp_byte7,
   output logic [3:0]         rsp_report_length
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHK   = 3'd1;
   localparam logic [2:0] ST_LOAD  = 3'd2;
   localparam logic [2:0] ST_LATCH = 3'd3;
   localparam logic [2:0] ST_BIT   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam int RW = ieth_pkg::MAP_ROW_W;
   localparam int RI = ieth_pkg::ROW_IDX_W;
   localparam int BI = ieth_pkg::BIT_IDX_W;
   localparam int KC = ieth_pkg::KEY_CODE_W;

   logic [2:0]    state_ff, state_in;
   logic [KC-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RI-1:0] key_row_ff, key_row_in;
   logic [BI-1:0] key_bit_ff, key_bit_in;
   logic          key_press_ff, key_press_in;
   logic [ieth_pkg::MAP_ROWS-1:0] row_valid_ff, row_valid_in;
   logic [2:0]    buttons_ff, buttons_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_id_ff, rsp_id_in;
   logic [7:0]    rsp_b1_ff, rsp_b1_in, rsp_b2_ff, rsp_b2_in, rsp_b3_ff, rsp_b3_in;
   logic [7:0]    rsp_b4_ff, rsp_b4_in, rsp_b5_ff, rsp_b5_in, rsp_b6_ff, rsp_b6_in;
   logic [7:0]    rsp_b7_ff, rsp_b7_in;
   logic [3:0]    rsp_len_ff, rsp_len_in;

   logic          ram_wr_en;
   logic [RI-1:0] ram_rd_addr;
   logic [RW-1:0] ram_rd_data;
   logic [RW-1:0] cur_row, next_row, bit_mask;

   logic          out_free, req_fire, kbd_load, mouse_load, btn_known;
   logic [2:0]    btn_mask, btn_next;
   logic [15:0]   m_dx, m_dy;
   logic [7:0]    m_wh;

   ieth_pkg::scan_ctl_type scan_ctl;
   logic [7:0]                          scan_mods;
   logic [ieth_pkg::MAX_SLOTS-1:0][7:0] scan_slots;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_fire  = req_valid && req_ready;

   assign ram_rd_addr = (state_ff == ST_IDLE) ? req_event_code[7:6] : cnt_ff[7:6];

   always_comb begin
      bit_mask             = '0;
      bit_mask[key_bit_ff] = 1'b1;
      cur_row  = row_valid_ff[key_row_ff] ? ram_rd_data : '0;
      next_row = key_press_ff ? (cur_row | bit_mask) : (cur_row & ~bit_mask);
   end

   always_comb begin
      btn_known = 1'b1;
      btn_mask  = 3'b000;
      priority if (req_event_code == ieth_pkg::BUTTON_CODE_LEFT) begin
         btn_mask = 3'b001;
      end else if (req_event_code == ieth_pkg::BUTTON_CODE_RIGHT) begin
         btn_mask = 3'b010;
      end else if (req_event_code == ieth_pkg::BUTTON_CODE_MIDDLE) begin
         btn_mask = 3'b100;
      end else begin
         btn_known = 1'b0;
      end
      btn_next = req_pressed ? (buttons_ff | btn_mask) : (buttons_ff & ~btn_mask);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      key_row_in   = key_row_ff;
      key_bit_in   = key_bit_ff;
      key_press_in = key_press_ff;
      row_valid_in = row_valid_ff;
      buttons_in   = buttons_ff;
      ram_wr_en    = 1'b0;
      scan_ctl     = '0;
      kbd_load     = 1'b0;
      mouse_load   = 1'b0;
      m_dx         = '0;
      m_dy         = '0;
      m_wh         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_mode)
                  ieth_pkg::MODE_KEY: begin
                     key_row_in   = req_event_code[7:6];
                     key_bit_in   = req_event_code[5:0];
                     key_press_in = req_pressed;
                     state_in     = ST_CHK;
                  end
                  ieth_pkg::MODE_MOVE: begin
                     mouse_load = 1'b1;
                     m_dx       = req_delta_x;
                     m_dy       = req_delta_y;
                  end
                  ieth_pkg::MODE_BUTTON: begin
                     if (btn_known && (btn_next != buttons_ff)) begin
                        buttons_in = btn_next;
                        mouse_load = 1'b1;
                     end
                  end
                  ieth_pkg::MODE_WHEEL: begin
                     mouse_load = 1'b1;
                     m_wh       = req_wheel_delta;
                  end
               endcase
            end
         end
         ST_CHK: begin
            if (next_row != cur_row) begin
               ram_wr_en                = 1'b1;
               row_valid_in[key_row_ff] = 1'b1;
               scan_ctl.start           = 1'b1;
               cnt_in                   = '0;
               state_in                 = ST_LOAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            state_in = ST_LATCH;
         end
         ST_LATCH: begin
            row_in   = row_valid_ff[cnt_ff[7:6]] ? ram_rd_data : '0;
            state_in = ST_BIT;
         end
         ST_BIT: begin
            scan_ctl.step = 1'b1;
            scan_ctl.held = row_ff[0];
            scan_ctl.code = cnt_ff;
            row_in        = row_ff >> 1;
            cnt_in        = cnt_ff + KC'(1);
            if (cnt_ff[5:0] == '1) begin
               state_in = (cnt_ff == '1) ? ST_OUT : ST_LOAD;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               kbd_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_id_in  = rsp_id_ff;
      rsp_b1_in  = rsp_b1_ff;
      rsp_b2_in  = rsp_b2_ff;
      rsp_b3_in  = rsp_b3_ff;
      rsp_b4_in  = rsp_b4_ff;
      rsp_b5_in  = rsp_b5_ff;
      rsp_b6_in  = rsp_b6_ff;
      rsp_b7_in  = rsp_b7_ff;
      rsp_len_in = rsp_len_ff;
      priority if (kbd_load) begin
         rsp_id_in  = ieth_pkg::REPORT_ID_KBD;
         rsp_b1_in  = scan_mods;
         rsp_b2_in  = scan_slots[0];
         rsp_b3_in  = scan_slots[1];
         rsp_b4_in  = scan_slots[2];
         rsp_b5_in  = scan_slots[3];
         rsp_b6_in  = scan_slots[4];
         rsp_b7_in  = scan_slots[5];
         rsp_len_in = ieth_pkg::LEN_KBD;
      end else if (mouse_load) begin
         rsp_id_in  = ieth_pkg::REPORT_ID_MOUSE;
         rsp_b1_in  = {5'b00000, buttons_in};
         rsp_b2_in  = m_dx[7:0];
         rsp_b3_in  = m_dx[15:8];
         rsp_b4_in  = m_dy[7:0];
         rsp_b5_in  = m_dy[15:8];
         rsp_b6_in  = m_wh;
         rsp_b7_in  = 8'h00;
         rsp_len_in = ieth_pkg::LEN_MOUSE;
      end
      priority if (kbd_load || mouse_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         row_valid_ff <= '0;
         buttons_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_valid_ff <= row_valid_in;
         buttons_ff   <= buttons_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff       <= row_in;
      key_row_ff   <= key_row_in;
      key_bit_ff   <= key_bit_in;
      key_press_ff <= key_press_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_b1_ff    <= rsp_b1_in;
      rsp_b2_ff    <= rsp_b2_in;
      rsp_b3_ff    <= rsp_b3_in;
      rsp_b4_ff    <= rsp_b4_in;
      rsp_b5_ff    <= rsp_b5_in;
      rsp_b6_ff    <= rsp_b6_in;
      rsp_b7_ff    <= rsp_b7_in;
      rsp_len_ff   <= rsp_len_in;
   end

   ieth_ram #(
      .WIDTH (RW),
      .DEPTH (ieth_pkg::MAP_ROWS)
   ) u_key_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (key_row_ff),
      .wr_data (next_row),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ieth_scan #(
      .KEY_SLOTS (KEY_SLOTS)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .mods  (scan_mods),
      .slots (scan_slots)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_report_id     = rsp_id_ff;
   assign rsp_byte1         = rsp_b1_ff;
   assign rsp_byte2         = rsp_b2_ff;
   assign rsp_byte3         = rsp_b3_ff;
   assign rsp_byte4         = rsp_b4_ff;
   assign rsp_byte5         = rsp_b5_ff;
   assign rsp_byte6         = rsp_b6_ff;
   assign rsp_byte7         = rsp_b7_ff;
   assign rsp_report_length = rsp_len_ff;

   `IETH_ASSERT_IMP(a_busy_not_ready, (state_ff != ST_IDLE), !req_ready)
   `IETH_ASSERT_IMP(a_idle_cnt_zero, (state_ff == ST_IDLE), (cnt_ff == '0))
   `IETH_ASSERT_NXT(a_scan_end_report, (state_ff == ST_OUT) && out_free,
                    rsp_valid && (rsp_report_id == ieth_pkg::REPORT_ID_KBD))
   `IETH_ASSERT_IMP(a_spare_slot_zero,
                    rsp_valid && (rsp_report_id == ieth_pkg::REPORT_ID_KBD)
                    && (KEY_SLOTS < ieth_pkg::MAX_SLOTS), (rsp_byte7 == 8'h00))

endmodule
